// ----- sv/cordic_sine_cosine_assert.svh -----
// Assertion macros used by the cordic_sine_cosine port checker.
`ifndef CORDIC_SINE_COSINE_ASSERT_SVH
`define CORDIC_SINE_COSINE_ASSERT_SVH

// Checked outside reset only.
`define CSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CSC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/csc_pkg.sv -----
// Shared types, constants and helpers for the CORDIC sine/cosine unit.
package csc_pkg;

  localparam int XW        = 18;  // x/y datapath width, Q1.15 plus headroom
  localparam int OW        = 16;  // result width
  localparam int MAX_STEPS = 30;

  localparam logic signed [XW-1:0] X_START  = 18'sd19898;  // 0.60725293 in Q1.15
  localparam logic signed [XW-1:0] SAT_POS  = 18'sd32767;
  localparam logic signed [XW-1:0] SAT_NEG  = -18'sd32767;

  // angle mod 360 via reciprocal: u = deg + 360*92 is never negative
  localparam logic [16:0] DEG_OFFSET  = 17'd33120;
  localparam logic [16:0] RECIP       = 17'd93207;  // ceil(2^25 / 360)
  localparam int          RECIP_SHIFT = 25;

  localparam logic signed [9:0] DEG_360 = 10'sd360;
  localparam logic signed [9:0] DEG_180 = 10'sd180;
  localparam logic signed [9:0] DEG_90  = 10'sd90;
  localparam logic signed [9:0] DEG_45  = 10'sd45;

  // atan(2^-i), 45 deg = 2^29
  localparam logic [31:0] ATAN_ROM [MAX_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // fold flags carried with each request from front to back
  typedef struct packed {
    logic quad_neg;  // angle lay beyond +-90: negate both results
    logic oct_pos;   // remainder lay above +45: sin=x, cos=-y
    logic oct_neg;   // remainder lay below -45: sin=-x, cos=y
  } fold_t;

  function automatic logic signed [OW-1:0] sat16(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    if (v > SAT_POS) t = SAT_POS;
    else if (v < SAT_NEG) t = SAT_NEG;
    else t = v;
    return t[OW-1:0];
  endfunction

endpackage

// ----- sv/csc_front.sv -----
// Front end: angle reduction mod 360, fold into +-45 degrees, scaling to the target angle.
module csc_front import csc_pkg::*; #(
  parameter int IT = 16,
  parameter int AW = IT + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   in_angle,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [AW-1:0] out_target,
  output fold_t         out_fold
);

  typedef logic [AW-1:0] scale_tbl_t [64];

  // floor(m * 2^(IT-6) / 45) * 16 for m = 0..45
  function automatic scale_tbl_t build_scale();
    scale_tbl_t t;
    longint v;
    for (int m = 0; m < 64; m++) begin
      if (m <= 45) v = ((longint'(m) << (IT - 6)) / 45) * 16;
      else v = 0;
      t[m] = AW'(v);
    end
    return t;
  endfunction

  localparam scale_tbl_t SCALE = build_scale();

  logic        v1_r, v2_r;
  logic [16:0] u1_r, u2_r;
  logic [8:0]  q2_r;
  logic        en1, en2;
  logic [16:0] u_in;
  logic [33:0] prod;
  logic [16:0] q360, rem;
  logic [8:0]  r;
  logic signed [9:0] d0, d1, d2, dmag;
  logic [5:0]  mag;
  logic [AW-1:0] scaled;
  fold_t       fold;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign u_in     = {in_angle[15], in_angle} + DEG_OFFSET;
  assign prod     = {17'b0, u1_r} * {17'b0, RECIP};

  // r = u - 360*q, 360 = 256 + 64 + 32 + 8
  assign q360 = {q2_r, 8'b0} + {2'b0, q2_r, 6'b0} + {3'b0, q2_r, 5'b0}
              + {5'b0, q2_r, 3'b0};
  assign rem  = u2_r - q360;
  assign r    = rem[8:0];

  always_comb begin
    fold = '0;
    if (r > 9'd180) d0 = $signed({1'b0, r}) - DEG_360;
    else d0 = $signed({1'b0, r});
    d1 = d0;
    if (d0 > DEG_90) begin
      d1 = d0 - DEG_180;
      fold.quad_neg = 1'b1;
    end else if (d0 < -DEG_90) begin
      d1 = d0 + DEG_180;
      fold.quad_neg = 1'b1;
    end
    d2 = d1;
    if (d1 < -DEG_45) begin
      d2 = d1 + DEG_90;
      fold.oct_neg = 1'b1;
    end else if (d1 > DEG_45) begin
      d2 = d1 - DEG_90;
      fold.oct_pos = 1'b1;
    end
    dmag   = d2[9] ? -d2 : d2;
    mag    = dmag[5:0];
    scaled = SCALE[mag];
  end

  assign out_valid  = v2_r;
  assign out_target = d2[9] ? -scaled : scaled;
  assign out_fold   = fold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) u1_r <= u_in;
    if (en2 && v1_r) begin
      u2_r <= u1_r;
      q2_r <= prod[RECIP_SHIFT +: 9];
    end
  end

endmodule

// ----- sv/csc_queue.sv -----
// Two-entry request queue between front end and rotation core.
module csc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r, count_nxt;
  logic         push, pop;

  assign in_ready  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_data;
  end

endmodule

// ----- sv/csc_core.sv -----
// Back end: iterative CORDIC rotation, result fix-up and output register.
module csc_core import csc_pkg::*; #(
  parameter int IT = 16,
  parameter int AW = IT + 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            req_valid,
  output logic            req_ready,
  input  logic [AW-1:0]   req_target,
  input  fold_t           req_fold,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [OW-1:0]   out_sine,
  output logic [OW-1:0]   out_cosine
);

  localparam int CW = $clog2(IT);
  localparam logic [CW-1:0] LAST = CW'(IT - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  typedef logic signed [AW-1:0] atan_tbl_t [2**CW];

  // atan(2^-i) rounded to the scale 45 deg = 2^(IT-2)
  function automatic atan_tbl_t build_atan();
    atan_tbl_t t;
    longint v;
    for (int i = 0; i < 2**CW; i++) begin
      if (i < IT) v = (longint'(ATAN_ROM[i]) + (longint'(1) << (30 - IT))) >>> (31 - IT);
      else v = 0;
      t[i] = AW'(v);
    end
    return t;
  endfunction

  localparam atan_tbl_t ATAN = build_atan();

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [AW-1:0] s_r, s_nxt, target_r, diff;
  fold_t                fold_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [OW-1:0]        sine_r, cosine_r;
  logic signed [XW-1:0] xs, ys, xa, sv, cv;
  logic                 dir_pos, load_req, load_out;

  assign req_ready = (state_r == ST_IDLE);
  assign load_req  = req_valid && req_ready;
  assign diff      = target_r - s_r;
  assign dir_pos   = !diff[AW-1] && (diff != '0);
  assign xs        = x_r >>> cnt_r;
  assign ys        = y_r >>> cnt_r;

  // fix-up: |x|, swap per octant flag, negate per quadrant flag
  always_comb begin
    xa = x_r[XW-1] ? -x_r : x_r;
    if (fold_r.oct_pos) begin
      sv = xa;
      cv = -y_r;
    end else if (fold_r.oct_neg) begin
      sv = -xa;
      cv = y_r;
    end else begin
      sv = y_r;
      cv = xa;
    end
    if (fold_r.quad_neg) begin
      sv = -sv;
      cv = -cv;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    s_nxt         = s_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load_out      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          x_nxt     = X_START;
          y_nxt     = '0;
          s_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (dir_pos) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          s_nxt = s_r + ATAN[cnt_r];
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          s_nxt = s_r - ATAN[cnt_r];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    s_r   <= s_nxt;
    if (load_req) begin
      target_r <= req_target;
      fold_r   <= req_fold;
    end
    if (load_out) begin
      sine_r   <= sat16(sv);
      cosine_r <= sat16(cv);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sine   = sine_r;
  assign out_cosine = cosine_r;

endmodule

// ----- sv/cordic_sine_cosine.sv -----
// Top level of the CORDIC sine/cosine unit.
// Takes an angle in whole degrees (any 16-bit signed value, reduced mod 360) and
// returns its sine and cosine as signed Q1.15, saturated to +-32767. The front end
// reduces the angle (reciprocal multiply, registered, then one subtract), folds it
// into +-45 degrees with quadrant/octant flags and scales it so 45 deg = 2^(IT-2);
// it holds up to two requests. A two-entry queue decouples it from the rotation
// core, which runs ITERATIONS CORDIC steps on one shared shift-add unit.
// The core takes one request at a time: a load, ITERATIONS rotation steps, then a
// fix-up into the output register; it takes the next only after that. An accepted
// angle passes the two front-end registers and the queue before the core. The
// input keeps accepting while a result waits in the output register until the
// front end and queue are full.
module cordic_sine_cosine import csc_pkg::*; #(
  parameter int ITERATIONS = 16  // rotation steps, 8..30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] angle_degrees
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] sine, [31:16] cosine
);

  localparam int AW = ITERATIONS + 2;      // angle accumulator width
  localparam int FW = $bits(fold_t);
  localparam int QW = AW + FW;

  logic          fe_valid, fe_ready;
  logic [AW-1:0] fe_target;
  fold_t         fe_fold;

  logic          rq_valid, rq_ready;
  logic [QW-1:0] rq_data;
  logic [OW-1:0] sine, cosine;

  // front end: reduce, fold, scale
  csc_front #(.IT(ITERATIONS), .AW(AW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_angle   (in_tdata),
    .out_valid  (fe_valid),
    .out_ready  (fe_ready),
    .out_target (fe_target),
    .out_fold   (fe_fold)
  );

  // request queue: {target, fold flags}
  csc_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_data   ({fe_target, fe_fold}),
    .out_valid (rq_valid),
    .out_ready (rq_ready),
    .out_data  (rq_data)
  );

  // rotation core with output register
  csc_core #(.IT(ITERATIONS), .AW(AW)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (rq_valid),
    .req_ready  (rq_ready),
    .req_target (rq_data[QW-1:FW]),
    .req_fold   (fold_t'(rq_data[FW-1:0])),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sine   (sine),
    .out_cosine (cosine)
  );

  assign out_tdata = {cosine, sine};

endmodule

// ----- sv/csc_checker.sv -----
// Port-level checker for cordic_sine_cosine, bound to the top level.
`include "cordic_sine_cosine_assert.svh"
module csc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic [2:0] pending_r, pending_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) pending_nxt = pending_r + 3'd1;
    else if (out_acc && !in_acc) pending_nxt = pending_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pending_r <= 3'd0;
    else pending_r <= pending_nxt;
  end

  `CSC_ASSERT_RST(a_reset_clears, !rst_n |=> !out_tvalid, "out_tvalid set after reset")
  `CSC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `CSC_ASSERT(a_no_spurious, out_tvalid |-> pending_r != 3'd0, "result without request")
  `CSC_ASSERT(a_capacity, pending_r <= 3'd6, "more requests in flight than storage")
  `CSC_ASSERT(a_saturated, out_tvalid |-> out_tdata[15:0] != 16'h8000 && out_tdata[31:16] != 16'h8000, "result below -32767")

endmodule

bind cordic_sine_cosine csc_checker u_csc_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the cordic_sine_cosine angle-to-sine/cosine unit.
module testbench;

  localparam int STEPS     = 16;        // rotation steps of the unit under test
  localparam int X_GAIN    = 19898;     // 0.60725293 in Q1.15
  localparam int Q15_LIMIT = 32767;
  localparam int IDLE_PCT  = 25;

  // atan(2^-i), 45 degrees = 2^29; rescaled to 45 degrees = 2^(STEPS-2) below
  localparam logic [31:0] ATAN_Q29 [0:STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D
  };

  typedef struct {
    logic signed [15:0] angle;
    bit                 drain_first;  // hold this request until all results are back
  } angle_req_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
  } sincos_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [15:0] angle_degrees
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [15:0] sine, [31:16] cosine

  angle_req_t pending_angles[$];
  sincos_t    expected_sincos[$];
  int         sent_count     = 0;
  int         checked_count  = 0;
  int         mismatch_count = 0;
  int         directed_count = 0;
  int         stall_left     = 0;
  bit         stall_done     = 1'b0;

  cordic_sine_cosine #(.ITERATIONS(STEPS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint clamp_q15(input longint v);
    if (v > Q15_LIMIT) return Q15_LIMIT;
    if (v < -Q15_LIMIT) return -Q15_LIMIT;
    return v;
  endfunction

  // Bit-exact sine/cosine of an angle in whole degrees.
  function automatic sincos_t sincos_of_degrees(input logic signed [15:0] angle);
    longint  deg, mag, target, x, y, acc, xs, ys, step_angle, s_res, c_res;
    int      quad, octant, i;
    sincos_t r;
    deg = angle;
    // reduce into -179..180
    deg = deg % 360;
    if (deg < 0) deg += 360;
    if (deg > 180) deg -= 360;
    quad   = 1;
    octant = 0;
    // fold beyond +-90 onto the other half-plane, negating both outputs
    if (deg > 90) begin
      deg -= 180;
      quad = -1;
    end else if (deg < -90) begin
      deg += 180;
      quad = -1;
    end
    // fold beyond +-45 by a quarter turn, swapping sine and cosine
    if (deg < -45) begin
      deg += 90;
      octant = -1;
    end else if (deg > 45) begin
      deg -= 90;
      octant = 1;
    end
    // scale so 45 degrees = 2^(STEPS-2), truncating the divide
    mag    = (deg < 0) ? -deg : deg;
    mag    = ((mag <<< (STEPS - 6)) / 45) * 16;
    target = (deg < 0) ? -mag : mag;
    x   = X_GAIN;
    y   = 0;
    acc = 0;
    for (i = 0; i < STEPS; i++) begin
      step_angle = longint'((64'(ATAN_Q29[i]) + (64'd1 << (30 - STEPS))) >> (31 - STEPS));
      xs = x >>> i;  // floor shifts, no rounding
      ys = y >>> i;
      // ties rotate negative
      if (target - acc > 0) begin
        x   = x - ys;
        y   = y + xs;
        acc = acc + step_angle;
      end else begin
        x   = x + ys;
        y   = y - xs;
        acc = acc - step_angle;
      end
    end
    if (x < 0) x = -x;
    if (octant > 0) begin
      s_res = x;
      c_res = -y;
    end else if (octant < 0) begin
      s_res = -x;
      c_res = y;
    end else begin
      s_res = y;
      c_res = x;
    end
    r.angle  = angle;
    r.sine   = 16'(clamp_q15(s_res * quad));
    r.cosine = 16'(clamp_q15(c_res * quad));
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Request driver: offers queued angles, idles at random except in a burst window,
  // and holds a marked request back until every outstanding result has come.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_sincos.push_back(sincos_of_degrees(in_tdata));
        sent_count++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_angles.size() != 0
            && !(pending_angles[0].drain_first && expected_sincos.size() != 0)
            && ((sent_count >= 250 && sent_count < 450)
                || $urandom_range(99) >= IDLE_PCT)) begin
          in_tdata  <= pending_angles[0].angle;
          in_tvalid <= 1'b1;
          pending_angles.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result against the oldest prediction and
  // drives out_tready, including one long hold-off to back the unit up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_sincos.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          if (out_tdata[15:0] !== expected_sincos[0].sine)
            report_mismatch($sformatf("angle %0d: sine %0d, expected %0d",
              expected_sincos[0].angle, $signed(out_tdata[15:0]),
              expected_sincos[0].sine));
          if (out_tdata[31:16] !== expected_sincos[0].cosine)
            report_mismatch($sformatf("angle %0d: cosine %0d, expected %0d",
              expected_sincos[0].angle, $signed(out_tdata[31:16]),
              expected_sincos[0].cosine));
          expected_sincos.pop_front();
        end
        checked_count++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!stall_done && checked_count == 600) begin
        // long hold-off: input side keeps offering and must stall
        stall_left = 300;
        stall_done = 1'b1;
        out_tready <= 1'b0;
      end else if (checked_count >= 250 && checked_count < 450) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    automatic int directed_angles[$] = '{
      -32768, 32767, 0, 1, -1, 44, 45, 46, -45, -46, 89, 90, 91, -90, -91,
      135, -135, 179, 180, -180, 181, 270, -270, 360, -360
    };
    automatic angle_req_t req;
    automatic int         pick;
    foreach (directed_angles[k]) begin
      req.angle       = 16'(directed_angles[k]);
      req.drain_first = 1'b0;
      pending_angles.push_back(req);
    end
    directed_count = pending_angles.size();
    for (int n = 0; n < 1050; n++) begin
      pick = $urandom_range(99);
      if (pick < 55)
        req.angle = 16'($urandom_range(800) - 400);
      else if (pick < 80)
        // octant and quadrant edges, plus or minus one, wrapped by whole turns
        req.angle = 16'(int'($urandom_range(16)) * 45 - 360 + int'($urandom_range(2)) - 1
                        + 360 * (int'($urandom_range(180)) - 90));
      else
        req.angle = 16'($urandom_range(16'hFFFF));
      // wait for the directed part to drain, and once more mid-run
      req.drain_first = (n == 0) || (n == 800);
      pending_angles.push_back(req);
    end

    while (pending_angles.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_sincos.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (3 * (STEPS + 5)) @(posedge clk);

    $display("Ran %0d angles (%0d directed edges, rest random incl. fold boundaries)",
             sent_count, directed_count);
    $display("Checked %0d results across a long output stall and two full drains",
             checked_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
